[hw/rtl/wav_data_chunk_extractor_defines.svh]
`ifndef WAV_DATA_CHUNK_EXTRACTOR_DEFINES_SVH
`define WAV_DATA_CHUNK_EXTRACTOR_DEFINES_SVH

// same-cycle implication, sampled at the rising clock edge
`define WDCE_ASSERT_NOW(lbl, clk, off, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (off) (ante) |-> (cons)) \
        else $error("wdce check failed");

// next-cycle implication, sampled at the rising clock edge
`define WDCE_ASSERT_NEXT(lbl, clk, off, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (off) (ante) |=> (cons)) \
        else $error("wdce check failed");

`endif

[hw/rtl/wdce_pkg.sv]
`timescale 1ns / 1ps

package wdce_pkg;

    localparam int LENGTH_BITS  = 32;
    localparam int MIN_FILE     = 44;
    localparam int RIFF_HEADER  = 12;
    localparam int CHUNK_HEADER = 8;
    localparam int SAMPLE_BYTES = 2;
    localparam logic [31:0] DATA_ID = 32'h6461_7461;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHUNK,
        PH_SKIP,
        PH_LO,
        PH_HI,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_SAMPLE,
        KIND_EMPTY,
        KIND_ERROR
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] sample;
        logic               last;
    } t_result;

endpackage

[hw/rtl/wdce_ifs.sv]
`timescale 1ns / 1ps

interface wdce_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface wdce_sample_if;
    logic               valid;
    logic               ready;
    wdce_pkg::t_kind    kind;
    logic signed [15:0] sample;
    logic               last;

    modport source (output valid, output kind, output sample, output last, input ready);
    modport sink (input valid, input kind, input sample, input last, output ready);
endinterface

[hw/rtl/wav_data_chunk_extractor.sv]
`timescale 1ns / 1ps

// channel    dir  word                          handshake
// i_byte     in   data_byte[7:0], first_byte    valid/ready
// o_sample   out  kind[1:0], sample[15:0], last valid/ready
// i_cfg_*    in   file_length[31:0]             write enable, no ready
//
// one byte per cycle while i_byte.ready is high; the parse state updates at the accept edge
// a result is written into the output buffer at the edge that accepts the byte that causes it
// a two-word output buffer decouples the sides; i_byte.ready drops only when it is full
// synchronous active-low reset; the file length register resets to zero

module wav_data_chunk_extractor #(
    parameter int LENGTH_BITS = wdce_pkg::LENGTH_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    wdce_byte_if.sink   i_byte,
    wdce_sample_if.source o_sample
);

    localparam int L  = LENGTH_BITS;
    localparam int CW = ((L > 32) ? L : 32) + 2;

    logic [L-1:0]         r_file_length;
    logic [L-1:0]         r_pos, n_pos, cur_pos;
    wdce_pkg::t_phase     r_phase, n_phase, cur_phase;
    logic [31:0]          r_id, n_id, cur_id;
    logic [31:0]          r_size, n_size, cur_size;
    logic [32:0]          r_skip, n_skip, cur_skip;
    logic [30:0]          r_drem, n_drem, cur_drem;
    logic [7:0]           r_low, n_low, cur_low;
    logic [2:0]           r_hdr, n_hdr, cur_hdr;

    logic                 in_acc;
    logic [L:0]           pos1;
    logic [L:0]           fl_ext;
    logic [L-1:0]         rem;
    logic [CW-1:0]        rem_w, size_w, clip_w, skip_w;
    logic [31:0]          sh_id, sh_size;
    logic                 chunk_done, is_data, skip_err, short_file;
    logic [30:0]          clip_half;
    logic [30:0]          hi_drem;

    logic                 res_valid;
    wdce_pkg::t_result    res;

    wdce_pkg::t_result    r_buf [2];
    logic                 r_wr_ptr, r_rd_ptr;
    logic [1:0]           r_count;
    logic                 out_acc;

    assign in_acc  = i_byte.valid && i_byte.ready;
    assign out_acc = o_sample.valid && o_sample.ready;

    // restart applies before the byte is parsed
    always_comb begin
        if (i_byte.first_byte) begin
            cur_phase = wdce_pkg::PH_HEADER;
            cur_pos   = '0;
            cur_id    = '0;
            cur_size  = '0;
            cur_skip  = '0;
            cur_drem  = '0;
            cur_low   = '0;
            cur_hdr   = '0;
        end else begin
            cur_phase = r_phase;
            cur_pos   = r_pos;
            cur_id    = r_id;
            cur_size  = r_size;
            cur_skip  = r_skip;
            cur_drem  = r_drem;
            cur_low   = r_low;
            cur_hdr   = r_hdr;
        end
    end

    // shared decode
    assign pos1   = {1'b0, cur_pos} + (L+1)'(1);
    assign fl_ext = {1'b0, r_file_length};
    assign rem    = (pos1 > fl_ext) ? '0 : L'(fl_ext - pos1);

    assign sh_id   = cur_hdr[2] ? cur_id : {cur_id[23:0], i_byte.data_byte};
    assign sh_size = cur_hdr[2] ? {i_byte.data_byte, cur_size[31:8]} : cur_size;

    assign rem_w     = CW'(rem);
    assign size_w    = CW'(sh_size);
    assign clip_w    = (size_w > rem_w) ? rem_w : size_w;
    assign clip_half = clip_w[31:1];
    assign skip_w    = size_w + CW'(sh_size[0]);
    assign skip_err  = (skip_w + CW'(wdce_pkg::CHUNK_HEADER)) > rem_w;

    assign chunk_done = (cur_phase == wdce_pkg::PH_CHUNK)
                     && (cur_hdr == 3'(wdce_pkg::CHUNK_HEADER - 1));
    assign is_data    = (sh_id == wdce_pkg::DATA_ID);
    assign short_file = (cur_pos == '0)
                     && (r_file_length < L'(wdce_pkg::MIN_FILE));
    assign hi_drem    = cur_drem - 31'(cur_drem != '0);

    // next state
    always_comb begin
        n_phase = cur_phase;
        n_pos   = cur_pos;
        n_id    = cur_id;
        n_size  = cur_size;
        n_skip  = cur_skip;
        n_drem  = cur_drem;
        n_low   = cur_low;
        n_hdr   = cur_hdr;
        unique case (cur_phase)
            wdce_pkg::PH_HEADER: begin
                if (short_file) begin
                    n_phase = wdce_pkg::PH_DONE;
                end else if (cur_pos >= L'(wdce_pkg::RIFF_HEADER - 1)) begin
                    n_phase = wdce_pkg::PH_CHUNK;
                    n_hdr   = '0;
                end
            end
            wdce_pkg::PH_CHUNK: begin
                n_id   = sh_id;
                n_size = sh_size;
                n_hdr  = cur_hdr + 3'd1;
                if (chunk_done) begin
                    if (is_data) begin
                        n_drem  = clip_half;
                        n_phase = (clip_half == '0) ? wdce_pkg::PH_DONE : wdce_pkg::PH_LO;
                    end else if (skip_err) begin
                        n_phase = wdce_pkg::PH_DONE;
                    end else if (skip_w == '0) begin
                        n_phase = wdce_pkg::PH_CHUNK;
                    end else begin
                        n_skip  = skip_w[32:0];
                        n_phase = wdce_pkg::PH_SKIP;
                    end
                end
            end
            wdce_pkg::PH_SKIP: begin
                n_skip = cur_skip - 33'(cur_skip != '0);
                if (n_skip == '0) begin
                    n_phase = wdce_pkg::PH_CHUNK;
                    n_hdr   = '0;
                end
            end
            wdce_pkg::PH_LO: begin
                n_low   = i_byte.data_byte;
                n_phase = wdce_pkg::PH_HI;
            end
            wdce_pkg::PH_HI: begin
                n_drem  = hi_drem;
                n_phase = (hi_drem == '0) ? wdce_pkg::PH_DONE : wdce_pkg::PH_LO;
            end
            default: begin
                n_phase = wdce_pkg::PH_DONE;
            end
        endcase
        if (n_phase != wdce_pkg::PH_DONE) begin
            n_pos = cur_pos + L'(1);
        end
    end

    // result word
    always_comb begin
        res_valid  = 1'b0;
        res.kind   = wdce_pkg::KIND_SAMPLE;
        res.sample = '0;
        res.last   = 1'b0;
        unique case (cur_phase)
            wdce_pkg::PH_HEADER: begin
                if (short_file) begin
                    res_valid = 1'b1;
                    res.kind  = wdce_pkg::KIND_ERROR;
                end
            end
            wdce_pkg::PH_CHUNK: begin
                if (chunk_done) begin
                    if (is_data && clip_half == '0) begin
                        res_valid = 1'b1;
                        res.kind  = wdce_pkg::KIND_EMPTY;
                    end else if (!is_data && skip_err) begin
                        res_valid = 1'b1;
                        res.kind  = wdce_pkg::KIND_ERROR;
                    end
                end
            end
            wdce_pkg::PH_HI: begin
                res_valid  = 1'b1;
                res.sample = {i_byte.data_byte, cur_low};
                res.last   = (hi_drem == '0);
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_length <= '0;
        end else if (i_cfg_we) begin
            r_file_length <= L'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= wdce_pkg::PH_HEADER;
            r_pos   <= '0;
            r_id    <= '0;
            r_size  <= '0;
            r_skip  <= '0;
            r_drem  <= '0;
            r_low   <= '0;
            r_hdr   <= '0;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_id    <= n_id;
            r_size  <= n_size;
            r_skip  <= n_skip;
            r_drem  <= n_drem;
            r_low   <= n_low;
            r_hdr   <= n_hdr;
        end
    end

    // two-word output buffer
    always_ff @(posedge i_clk) begin
        if (in_acc && res_valid) begin
            r_buf[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (in_acc && res_valid) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (out_acc) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(in_acc && res_valid) - 2'(out_acc);
        end
    end

    assign i_byte.ready    = (r_count != 2'd2);
    assign o_sample.valid  = (r_count != 2'd0);
    assign o_sample.kind   = r_buf[r_rd_ptr].kind;
    assign o_sample.sample = r_buf[r_rd_ptr].sample;
    assign o_sample.last   = r_buf[r_rd_ptr].last;

endmodule

[hw/rtl/wdce_checker.sv]
`timescale 1ns / 1ps
`include "wav_data_chunk_extractor_defines.svh"

module wdce_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         i_out_kind,
    input logic signed [15:0] i_out_sample,
    input logic               i_out_last
);

    `WDCE_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_kind) && $stable(i_out_sample) && $stable(i_out_last))
    `WDCE_ASSERT_NOW(a_nonsample_clean, i_clk, !i_rst_n, i_out_valid && i_out_kind != 2'(wdce_pkg::KIND_SAMPLE), i_out_sample == '0 && !i_out_last)
    `WDCE_ASSERT_NOW(a_kind_legal, i_clk, !i_rst_n, i_out_valid, i_out_kind != 2'd3)
    `WDCE_ASSERT_NOW(a_stall_only_full, i_clk, !i_rst_n, !i_in_ready, i_out_valid)
    `WDCE_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !i_out_valid && i_in_ready)

endmodule

bind wav_data_chunk_extractor wdce_checker u_wdce_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_byte.valid),
    .i_in_ready   (i_byte.ready),
    .i_out_valid  (o_sample.valid),
    .i_out_ready  (o_sample.ready),
    .i_out_kind   (o_sample.kind),
    .i_out_sample (o_sample.sample),
    .i_out_last   (o_sample.last)
);
